FILE: rtl/brse_pkg.sv
// Shared constants and types for the bitmap row span extractor.
// No dependencies; every other file of the block imports this package.
package brse_pkg;

	localparam int unsigned PIX_W      = 8;
	localparam int unsigned COL_W      = 13;
	localparam int unsigned ROW_W      = 12;
	localparam int unsigned LEFT_W     = 12;
	localparam int unsigned LANES      = PIX_W;
	localparam int unsigned OUT_MAX    = 4;
	localparam int unsigned SLOTS      = OUT_MAX + 1;
	localparam int unsigned CANDS      = LANES + 2;
	localparam int unsigned CNT_W      = $clog2(CANDS + 1);
	localparam int unsigned QCNT_W     = $clog2(OUT_MAX + 1);

	localparam int unsigned MAX_WIDTH  = 4096;
	localparam int unsigned MAX_HEIGHT = 4096;

	localparam logic [COL_W-1:0] ROW_WIDTH_RST = COL_W'(8);

	typedef struct packed {
		logic [LEFT_W-1:0] left;
		logic [COL_W-1:0]  right;
		logic [ROW_W-1:0]  row;
	} span_t;

	typedef struct packed {
		logic              run;
		logic [LEFT_W-1:0] start;
		logic              close;
		logic [LEFT_W-1:0] close_left;
		logic [COL_W-1:0]  close_right;
	} lane_t;

	typedef struct packed {
		span_t span;
		logic  last;
	} qent_t;

	typedef struct packed {
		logic              can_load;
		logic [QCNT_W-1:0] cnt;
	} qstat_t;

endpackage

FILE: rtl/brse_if.sv
// Request channel interfaces: pixel bytes in, spans out.
// Depends on brse_pkg for the payload widths.
interface brse_in_if import brse_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_bits;
	logic             image_start;

	modport source (output valid, pixel_bits, image_start, input ready);
	modport sink (input valid, pixel_bits, image_start, output ready);
endinterface

interface brse_out_if import brse_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [LEFT_W-1:0] span_left;
	logic [COL_W-1:0]  span_right;
	logic [ROW_W-1:0]  span_row;
	logic              last_span;

	modport source (output valid, span_left, span_right, span_row, last_span, input ready);
	modport sink (input valid, span_left, span_right, span_row, last_span, output ready);
endinterface

FILE: rtl/brse_lane.sv
// One pixel lane: checks its column against the row width and detects run edges.
// Depends on brse_pkg for lane_t.
module brse_lane import brse_pkg::*; (
	input  logic [COL_W-1:0]  col,
	input  logic [COL_W-1:0]  width,
	input  logic              pix,
	input  logic              prev_run,
	input  logic [LEFT_W-1:0] prev_start,
	output lane_t             res
);

	logic active;

	assign active = col < width;

	always_comb begin
		// pixels past the row end leave the run state untouched
		res.run         = active ? pix : prev_run;
		res.start       = (active && pix && !prev_run) ? col[LEFT_W-1:0] : prev_start;
		res.close       = active && !pix && prev_run;
		res.close_left  = prev_start;
		res.close_right = col;
	end

endmodule

FILE: rtl/brse_merge.sv
// Merging stage: packs the held span, lane closes and the row-end close in order.
// Depends on brse_pkg for span_t and lane_t.
module brse_merge import brse_pkg::*; (
	input  logic              hold_valid,
	input  span_t             hold_span,
	input  lane_t             lanes [LANES],
	input  logic [ROW_W-1:0]  row,
	input  logic              end_close,
	input  span_t             end_span,
	output span_t             slots [SLOTS],
	output logic [CNT_W-1:0]  total
);

	logic [CANDS-1:0] cand_v;
	span_t            cand [CANDS];
	logic [CNT_W-1:0] pos [CANDS];

	always_comb begin
		cand_v[0] = hold_valid;
		cand[0]   = hold_span;
		for (int i = 0; i < LANES; i++) begin
			cand_v[i+1] = lanes[i].close;
			cand[i+1]   = '{left: lanes[i].close_left, right: lanes[i].close_right, row: row};
		end
		cand_v[CANDS-1] = end_close;
		cand[CANDS-1]   = end_span;
	end

	// slot of each candidate is the number of valid candidates ahead of it
	always_comb begin
		for (int i = 0; i < CANDS; i++) begin
			pos[i] = CNT_W'($countones(cand_v & ((CANDS'(1) << i) - CANDS'(1))));
		end
	end

	assign total = CNT_W'($countones(cand_v));

	always_comb begin
		for (int k = 0; k < SLOTS; k++) begin
			slots[k] = '0;
			for (int i = 0; i < CANDS; i++) begin
				if (cand_v[i] && pos[i] == CNT_W'(k)) begin
					slots[k] = slots[k] | cand[i];
				end
			end
		end
	end

endmodule

FILE: rtl/brse_span_queue.sv
// Span buffer for one byte's spans, drained one a cycle, unless the output stalls, into an output register.
// Depends on brse_pkg for span_t, qent_t and qstat_t.
module brse_span_queue import brse_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  span_t             load_span [OUT_MAX],
	input  logic [QCNT_W-1:0] load_cnt,
	output qstat_t            stat,
	output logic              out_valid,
	input  logic              out_ready,
	output qent_t             out_ent
);

	qent_t             ent_q [OUT_MAX];
	logic [QCNT_W-1:0] cnt_q;
	logic              ov_q;
	qent_t             out_q;
	logic              move;

	assign move          = (cnt_q != '0) && (!ov_q || out_ready);
	assign stat.can_load = (cnt_q == '0) || (cnt_q == QCNT_W'(1) && move);
	assign stat.cnt      = cnt_q;
	assign out_valid     = ov_q;
	assign out_ent       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (load) begin
				cnt_q <= load_cnt;
			end else if (move) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
			if (move) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < OUT_MAX; k++) begin
				ent_q[k] <= '{span: load_span[k], last: (QCNT_W'(k + 1) == load_cnt)};
			end
		end else if (move) begin
			// advance the remaining spans towards the head
			for (int k = 0; k < OUT_MAX - 1; k++) begin
				ent_q[k] <= ent_q[k+1];
			end
		end
		if (move) begin
			out_q <= ent_q[0];
		end
	end

endmodule

FILE: rtl/bitmap_row_span_extractor_unit.sv
// Bitmap row span extractor: takes one 1-bpp byte per request and turns each run of
// set pixels into a span (left, exclusive right, row). Eight pixel lanes inspect the
// byte side by side and a merging stage packs the spans found; the row position and
// run state update in the cycle the byte is accepted, so a byte that yields no span
// or one span is taken every cycle unless the span output stalls. A byte with more than
// one span holds the input while the output drains them one a cycle when not stalled;
// a fifth span from one byte is kept and sent first with the next byte's spans. A byte's
// first span passes the span buffer, then the output register, and later ones follow it in
// order; a stalled output holds the input while the buffer is not empty.
// row_width may only be written while the block is idle.
// Depends on brse_pkg, brse_if, brse_lane, brse_merge and brse_span_queue.
module bitmap_row_span_extractor_unit import brse_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [COL_W-1:0] cfg_wr_data,
	brse_in_if.sink          pix,
	brse_out_if.source       spans
);

	logic [COL_W-1:0]  row_width_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic              in_run_q;
	logic [LEFT_W-1:0] run_start_q;
	logic              hold_valid_q;
	span_t             hold_q;

	logic              accept;
	logic [COL_W-1:0]  width_eff;
	logic [COL_W-1:0]  col0;
	logic [ROW_W-1:0]  row0;
	logic              run0;
	logic [LEFT_W-1:0] start0;
	lane_t             lane_o [LANES];
	logic              row_end;
	logic              end_close;
	span_t             end_span;
	logic [ROW_W:0]    row_inc;
	logic [ROW_W-1:0]  row_next;
	span_t             slots [SLOTS];
	logic [CNT_W-1:0]  total;
	logic [QCNT_W-1:0] n_out;
	span_t             q_span [OUT_MAX];
	qstat_t            q_stat;
	logic              out_valid;
	qent_t             out_ent;

	assign accept    = pix.valid && pix.ready;
	assign pix.ready = q_stat.can_load;

	assign width_eff = (row_width_q > COL_W'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH) : row_width_q;

	// image start drops the open run and returns to the top left
	assign col0   = pix.image_start ? '0 : col_q;
	assign row0   = pix.image_start ? '0 : row_q;
	assign run0   = pix.image_start ? 1'b0 : in_run_q;
	assign start0 = pix.image_start ? '0 : run_start_q;

	for (genvar b = 0; b < LANES; b++) begin : g_lane
		if (b == 0) begin : g_first
			brse_lane u_lane (
				.col        (col0),
				.width      (width_eff),
				.pix        (pix.pixel_bits[b]),
				.prev_run   (run0),
				.prev_start (start0),
				.res        (lane_o[b])
			);
		end else begin : g_next
			brse_lane u_lane (
				.col        (col0 + COL_W'(b)),
				.width      (width_eff),
				.pix        (pix.pixel_bits[b]),
				.prev_run   (lane_o[b-1].run),
				.prev_start (lane_o[b-1].start),
				.res        (lane_o[b])
			);
		end
	end

	assign row_end   = !((col0 + COL_W'(LANES)) < width_eff);
	assign end_close = row_end && lane_o[LANES-1].run;
	assign end_span  = '{
		left:  lane_o[LANES-1].start,
		right: (col0 < width_eff) ? width_eff : col0,
		row:   row0
	};

	assign row_inc  = {1'b0, row0} + (ROW_W + 1)'(1);
	assign row_next = (row_inc >= (ROW_W + 1)'(MAX_HEIGHT)) ? '0 : row_inc[ROW_W-1:0];

	brse_merge u_merge (
		.hold_valid (hold_valid_q),
		.hold_span  (hold_q),
		.lanes      (lane_o),
		.row        (row0),
		.end_close  (end_close),
		.end_span   (end_span),
		.slots      (slots),
		.total      (total)
	);

	assign n_out = (total > CNT_W'(OUT_MAX)) ? QCNT_W'(OUT_MAX) : total[QCNT_W-1:0];

	always_comb begin
		for (int k = 0; k < OUT_MAX; k++) begin
			q_span[k] = slots[k];
		end
	end

	brse_span_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.load_span (q_span),
		.load_cnt  (n_out),
		.stat      (q_stat),
		.out_valid (out_valid),
		.out_ready (spans.ready),
		.out_ent   (out_ent)
	);

	assign spans.valid      = out_valid;
	assign spans.span_left  = out_ent.span.left;
	assign spans.span_right = out_ent.span.right;
	assign spans.span_row   = out_ent.span.row;
	assign spans.last_span  = out_ent.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q  <= ROW_WIDTH_RST;
			col_q        <= '0;
			row_q        <= '0;
			in_run_q     <= 1'b0;
			run_start_q  <= '0;
			hold_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				row_width_q <= cfg_wr_data;
			end
			if (accept) begin
				col_q        <= row_end ? '0 : col0 + COL_W'(LANES);
				row_q        <= row_end ? row_next : row0;
				in_run_q     <= !row_end && lane_o[LANES-1].run;
				run_start_q  <= lane_o[LANES-1].start;
				hold_valid_q <= total > CNT_W'(OUT_MAX);
			end
		end
	end

	// hold the fifth span for the next byte
	always_ff @(posedge clk) begin
		if (accept) begin
			hold_q <= slots[OUT_MAX];
		end
	end

`ifndef SYNTHESIS
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_W'(MAX_WIDTH))
		else $error("column position beyond the maximum row width");

	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_run_q |-> ({1'b0, run_start_q} < col_q))
		else $error("open run starts at or after the current column");

	a_hold_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hold_valid_q) |-> $past(accept))
		else $error("held span appeared without an accepted byte");

	a_queue_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.cnt <= QCNT_W'(OUT_MAX))
		else $error("span buffer count above capacity");
`endif

endmodule

FILE: tb/sv/brse_span_tracker_pkg.sv
`timescale 1ns / 1ps
// Span tracker for the bitmap row span extractor bench: predicts the spans of each byte
// and checks the spans that leave the block. Depends on brse_pkg.
package brse_span_tracker_pkg;
	import brse_pkg::*;

	localparam int unsigned BURST_CAP = SLOTS + 1;
	localparam int unsigned REPORT_MAX = 10;

	class span_tracker;
		logic [COL_W-1:0]  width_reg;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		bit                run_open;
		logic [LEFT_W-1:0] run_left;
		bit                held;
		span_t             held_span;
		span_t             burst[$];
		qent_t             spans_due[$];
		int                errors;
		int                spans_ok;
		int                bytes_noted;
		int                five_span_bytes;

		function new();
			width_reg = ROW_WIDTH_RST;
			col = '0;
			row = '0;
			run_open = 0;
			run_left = '0;
			held = 0;
			held_span = '0;
			errors = 0;
			spans_ok = 0;
			bytes_noted = 0;
			five_span_bytes = 0;
		endfunction

		function void set_width(logic [COL_W-1:0] w);
			width_reg = w;
		endfunction

		function int pending();
			return spans_due.size();
		endfunction

		function void add_span(logic [LEFT_W-1:0] left, logic [COL_W-1:0] right,
			logic [ROW_W-1:0] r);
			span_t s;
			s.left = left;
			s.right = right;
			s.row = r;
			// drop anything past the burst capacity
			if (burst.size() < BURST_CAP)
				burst.push_back(s);
		endfunction

		// Note one accepted request and queue the spans it releases.
		function void note_byte(logic [PIX_W-1:0] bits, logic start);
			int unsigned lim;
			int n;
			qent_t e;
			lim = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
			bytes_noted++;
			burst.delete();
			if (held) begin
				add_span(held_span.left, held_span.right, held_span.row);
				held = 0;
			end
			if (start) begin
				col = '0;
				row = '0;
				run_open = 0;
				run_left = '0;
			end
			for (int b = 0; b < PIX_W; b++) begin
				if (col < lim) begin
					if (bits[b] && !run_open) begin
						run_open = 1;
						run_left = col[LEFT_W-1:0];
					end else if (!bits[b] && run_open) begin
						add_span(run_left, col, row);
						run_open = 0;
					end
					col = col + 1'b1;
				end
			end
			if (col >= lim) begin
				if (run_open)
					add_span(run_left, col, row);
				run_open = 0;
				col = '0;
				row = (row == MAX_HEIGHT - 1) ? '0 : row + 1'b1;
			end
			n = (burst.size() < OUT_MAX) ? burst.size() : OUT_MAX;
			if (burst.size() > OUT_MAX) begin
				held = 1;
				held_span = burst[OUT_MAX];
				five_span_bytes++;
			end
			for (int k = 0; k < n; k++) begin
				e.span = burst[k];
				e.last = (k == n - 1);
				spans_due.push_back(e);
			end
		endfunction

		function void check_span(qent_t got);
			qent_t want;
			if (spans_due.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("unexpected span: left=%0d right=%0d row=%0d last=%0b",
						got.span.left, got.span.right, got.span.row, got.last);
				return;
			end
			want = spans_due.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("span mismatch: expected left=%0d right=%0d row=%0d last=%0b, %s",
						want.span.left, want.span.right, want.span.row, want.last,
						$sformatf("got left=%0d right=%0d row=%0d last=%0b",
						got.span.left, got.span.right, got.span.row, got.last));
			end else begin
				spans_ok++;
			end
		endfunction
	endclass

endpackage

FILE: tb/sv/bitmap_row_span_extractor_unit_tb.sv
`timescale 1ns / 1ps
// Bench for bitmap_row_span_extractor_unit: directed bytes, then random rows over several
// widths with random stalls on both channels. Depends on brse_pkg, brse_if and the tracker.
module bitmap_row_span_extractor_unit_tb;
	import brse_pkg::*;
	import brse_span_tracker_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE = 8;
	localparam int LONG_HOLD = 80;
	localparam int PHASES = 12;
	localparam int PHASE_BYTES = 30;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic [COL_W-1:0] cfg_wr_data = '0;

	brse_in_if  pix();
	brse_out_if spans();

	span_tracker tracker = new();

	int    cycles = 0;
	int    rx_stall = 0;
	int    hold_req = 0;
	int    hold_ack = 0;
	int    holdoffs = 0;
	int    widths_set = 0;
	bit    tx_steady = 0;
	bit    rx_steady = 0;
	qent_t rx_item;

	logic [COL_W-1:0] phase_width [PHASES] = '{
		13'd9, 13'd1, 13'd16, 13'd4096, 13'd24, 13'd2,
		13'd12, 13'd8, 13'd4095, 13'd40, 13'd5, 13'd17
	};

	bitmap_row_span_extractor_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.pix        (pix),
		.spans      (spans)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d spans still due", cycles, tracker.pending());
			$display("[bitmap_row_span_extractor_unit] ERROR");
			$finish;
		end
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(0, 2);
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixels();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h55;
			3: return 8'hAA;
			4, 5: return PIX_W'($urandom & $urandom);
			6: return PIX_W'($urandom | $urandom);
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Span receiver: check each accepted span, then choose next cycle's ready.
	always @(posedge clk) begin
		if (arst_n) begin
			if (spans.valid && spans.ready) begin
				rx_item.span.left = spans.span_left;
				rx_item.span.right = spans.span_right;
				rx_item.span.row = spans.span_row;
				rx_item.last = spans.last_span;
				tracker.check_span(rx_item);
			end
			if (hold_req != hold_ack) begin
				hold_ack <= hold_req;
				rx_stall <= LONG_HOLD;
				holdoffs <= holdoffs + 1;
				spans.ready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall <= rx_stall - 1;
				spans.ready <= 1'b0;
			end else if (!rx_steady && $urandom_range(0, 5) == 0) begin
				rx_stall <= pick_gap();
				spans.ready <= 1'b0;
			end else begin
				spans.ready <= 1'b1;
			end
		end else begin
			spans.ready <= 1'b0;
		end
	end

	task automatic send_byte(input logic [PIX_W-1:0] bits, input logic start);
		int gap;
		pix.valid <= 1'b1;
		pix.pixel_bits <= bits;
		pix.image_start <= start;
		@(posedge clk);
		while (!pix.ready)
			@(posedge clk);
		tracker.note_byte(bits, start);
		gap = tx_steady ? 0 : pick_gap();
		// keep valid high straight into the next request when there is no gap
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle_idle();
		pix.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
		// a byte with no span may still be in flight
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_width(input logic [COL_W-1:0] w);
		settle_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= w;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.set_width(w);
		widths_set++;
	endtask

	initial begin
		pix.valid <= 1'b0;
		pix.pixel_bits <= '0;
		pix.image_start <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-byte rows: extremes and alternating patterns
		write_width(13'd8);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h81, 1'b0);
		send_byte(8'h7E, 1'b0);

		// two-byte rows: five spans from one byte, held span ahead of the next byte
		write_width(13'd16);
		send_byte(8'h80, 1'b1);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'h80, 1'b1);
		// image start drops the open run
		send_byte(8'h00, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hAA, 1'b0);
		// held span still comes out ahead of an image start
		send_byte(8'h0F, 1'b1);

		// pixels past the row end are ignored
		write_width(13'd3);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hF8, 1'b0);

		// lower the width with a run open part-way along the row
		write_width(13'd16);
		send_byte(8'hF0, 1'b1);
		write_width(13'd5);
		send_byte(8'hFF, 1'b0);

		// empty rows
		write_width(13'd0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);

		write_width(13'd4096);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			write_width(phase_width[p]);
			tx_steady = (p == 7);
			rx_steady = (p == 7) || (p == 4);
			for (int i = 0; i < PHASE_BYTES; i++) begin
				// hold off the receiver while requests keep coming
				if (p == 2 && i == 3)
					hold_req <= hold_req + 1;
				if (i == PHASE_BYTES / 2 && p == 9)
					settle_idle();
				send_byte(pick_pixels(), (i == 0) || ($urandom_range(0, 24) == 0));
			end
		end

		tx_steady = 0;
		rx_steady = 0;
		settle_idle();
		$display("covered %0d bytes over %0d width settings, %0d spans checked",
			tracker.bytes_noted, widths_set, tracker.spans_ok);
		$display("%0d bytes closed five spans, %0d long receiver hold-offs, %0d mismatches",
			tracker.five_span_bytes, holdoffs, tracker.errors);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("[bitmap_row_span_extractor_unit] OK");
		else
			$display("[bitmap_row_span_extractor_unit] ERROR");
		$finish;
	end

endmodule
